### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect i_clk and i_rst_n in the enclosing module.

// Condition that holds at every clock edge out of reset.
`define ACGT_CHECK(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that holds in the same cycle as the antecedent.
`define ACGT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

### rtl/acgt_pkg.sv
package acgt_pkg;

    localparam int MAX_MIN_LENGTH = 32;
    localparam int BUF_AW         = $clog2(MAX_MIN_LENGTH);
    localparam int RUN_W          = 32;
    localparam int REC_W          = 31;
    localparam int CFG_W          = 6;
    localparam int DIGITS         = 10;
    localparam int DIG_W          = $clog2(DIGITS);

    localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(10);
    localparam logic [RUN_W-1:0] MAX_RUN       = RUN_W'(MAX_MIN_LENGTH);
    localparam logic [RUN_W-1:0] RUN_SAT       = '1;
    localparam logic [REC_W-1:0] REC_LAST      = '1;

    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_QUAL = 8'h49;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CASE_MASK = 8'hDF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_HDR_NL,
        ST_REPLAY,
        ST_CLOSE
    } t_state;

    typedef enum logic [1:0] {
        CL_PLUS,
        CL_NL,
        CL_QUAL,
        CL_END
    } t_close_step;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic inc;
        logic clr;
    } t_recno_cmd;

    typedef struct packed {
        t_bcd             digits;
        logic [DIG_W-1:0] msd;
    } t_recno_stat;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } t_buf_wr;

    function automatic logic is_base(input logic [7:0] ch);
        logic [7:0] u;
        u = ch & CASE_MASK;
        return (u == CH_A) || (u == CH_C) || (u == CH_G) || (u == CH_T);
    endfunction

    function automatic logic [RUN_W-1:0] idx_to_run(input logic [BUF_AW-1:0] idx);
        return {{(RUN_W-BUF_AW){1'b0}}, idx};
    endfunction

endpackage

### rtl/acgt_in_if.sv
interface acgt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_file;

    modport source (output valid, output in_byte, output end_of_file, input ready);
    modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

### rtl/acgt_out_if.sv
interface acgt_out_if;
    logic                       valid;
    logic                       ready;
    logic [7:0]                 out_char;
    logic [acgt_pkg::RUN_W-1:0] repeat_res;
    logic                       last;

    modport source (output valid, output out_char, output repeat_res, output last,
                    input ready);
    modport sink   (input valid, input out_char, input repeat_res, input last,
                    output ready);
endinterface

### rtl/acgt_cfg_if.sv
interface acgt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [acgt_pkg::CFG_W-1:0] min_length;

    modport source (output valid, output min_length, input ready);
    modport sink   (input valid, input min_length, output ready);
endinterface

### rtl/acgt_buf.sv
module acgt_buf (
    input  logic                        i_clk,
    input  acgt_pkg::t_buf_wr           i_wr,
    input  logic [acgt_pkg::BUF_AW-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] mem [acgt_pkg::MAX_MIN_LENGTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/acgt_recno.sv
module acgt_recno (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  acgt_pkg::t_recno_cmd  i_cmd,
    output acgt_pkg::t_recno_stat o_stat
);

    logic [acgt_pkg::REC_W-1:0] r_bin, n_bin;
    acgt_pkg::t_bcd             r_bcd, n_bcd;
    acgt_pkg::t_bcd             bcd_inc;
    logic [acgt_pkg::DIGITS:0]  carry;
    logic [acgt_pkg::DIG_W-1:0] msd;

    // Decimal copy of the count, so the header needs no binary-to-decimal step
    always_comb begin
        carry[0] = 1'b1;
        for (int i = 0; i < acgt_pkg::DIGITS; i++) begin
            carry[i+1] = carry[i] && (r_bcd[i] == 4'd9);
            if (!carry[i]) begin
                bcd_inc[i] = r_bcd[i];
            end else if (r_bcd[i] == 4'd9) begin
                bcd_inc[i] = 4'd0;
            end else begin
                bcd_inc[i] = r_bcd[i] + 4'd1;
            end
        end
    end

    always_comb begin
        msd = '0;
        for (int i = 0; i < acgt_pkg::DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) begin
                msd = acgt_pkg::DIG_W'(i);
            end
        end
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        priority if (i_cmd.clr) begin
            n_bin = '0;
            n_bcd = '0;
        end else if (i_cmd.inc) begin
            if (r_bin == acgt_pkg::REC_LAST) begin
                n_bin = '0;
                n_bcd = '0;
            end else begin
                n_bin = r_bin + acgt_pkg::REC_W'(1);
                n_bcd = bcd_inc;
            end
        end else begin
            n_bin = r_bin;
            n_bcd = r_bcd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin <= '0;
            r_bcd <= '0;
        end else begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
    end

    assign o_stat.digits = r_bcd;
    assign o_stat.msd    = msd;

endmodule

### rtl/acgt_ctrl.sv
`include "assert_macros.svh"

module acgt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    acgt_in_if.sink                     i_in,
    acgt_out_if.source                  o_out,
    acgt_cfg_if.sink                    i_cfg,
    input  acgt_pkg::t_recno_stat       i_rec,
    output acgt_pkg::t_recno_cmd        o_rec,
    output acgt_pkg::t_buf_wr           o_wr,
    output logic [acgt_pkg::BUF_AW-1:0] o_rd_addr,
    input  logic [7:0]                  i_rd_data
);

    acgt_pkg::t_state           r_state, n_state;
    acgt_pkg::t_close_step      r_cnt, n_cnt;
    logic [acgt_pkg::DIG_W-1:0] r_dig, n_dig;
    logic [acgt_pkg::BUF_AW-1:0] r_idx, n_idx;
    logic [acgt_pkg::RUN_W-1:0] r_run_len, n_run_len;
    logic                       r_open, n_open;
    logic                       r_eof, n_eof;
    logic [acgt_pkg::CFG_W-1:0] r_min_len;

    logic                       r_ovalid;
    logic [7:0]                 r_ochar;
    logic [acgt_pkg::RUN_W-1:0] r_orep;
    logic                       r_olast;

    logic                       emit;
    logic [7:0]                 e_char;
    logic [acgt_pkg::RUN_W-1:0] e_rep;
    logic                       e_last;

    logic                       out_free;
    logic                       accept;
    logic                       in_base;
    logic [acgt_pkg::RUN_W-1:0] thr;
    logic [acgt_pkg::RUN_W-1:0] len_inc;

    assign out_free   = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == acgt_pkg::ST_IDLE) && out_free;
    assign accept     = i_in.valid && i_in.ready;
    assign in_base    = acgt_pkg::is_base(i_in.in_byte);
    assign i_cfg.ready = 1'b1;

    // Clamp the threshold into 1..MAX_MIN_LENGTH
    always_comb begin
        priority if (r_min_len == '0) begin
            thr = acgt_pkg::RUN_W'(1);
        end else if (acgt_pkg::RUN_W'(r_min_len) > acgt_pkg::MAX_RUN) begin
            thr = acgt_pkg::MAX_RUN;
        end else begin
            thr = acgt_pkg::RUN_W'(r_min_len);
        end
    end

    assign len_inc = (r_run_len < acgt_pkg::MAX_RUN) ?
                     r_run_len + acgt_pkg::RUN_W'(1) : r_run_len;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_idx     = r_idx;
        n_run_len = r_run_len;
        n_open    = r_open;
        n_eof     = r_eof;
        emit      = 1'b0;
        e_char    = acgt_pkg::CH_NL;
        e_rep     = acgt_pkg::RUN_W'(1);
        e_last    = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.addr = r_run_len[acgt_pkg::BUF_AW-1:0];
        o_wr.data = i_in.in_byte;
        o_rec.inc = 1'b0;
        o_rec.clr = 1'b0;

        unique case (r_state)
            acgt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in.end_of_file || !in_base) begin
                        if (r_open) begin
                            emit    = 1'b1;
                            e_char  = acgt_pkg::CH_NL;
                            n_state = acgt_pkg::ST_CLOSE;
                            n_cnt   = acgt_pkg::CL_PLUS;
                            n_eof   = i_in.end_of_file;
                        end else begin
                            n_run_len = '0;
                            o_rec.clr = i_in.end_of_file;
                        end
                    end else if (r_open) begin
                        emit   = 1'b1;
                        e_char = i_in.in_byte;
                        e_last = 1'b1;
                        if (r_run_len != acgt_pkg::RUN_SAT) begin
                            n_run_len = r_run_len + acgt_pkg::RUN_W'(1);
                        end
                    end else begin
                        o_wr.en   = r_run_len < acgt_pkg::MAX_RUN;
                        n_run_len = len_inc;
                        if (len_inc >= thr) begin
                            emit    = 1'b1;
                            e_char  = acgt_pkg::CH_AT;
                            n_state = acgt_pkg::ST_DIGIT;
                            n_dig   = i_rec.msd;
                        end
                    end
                end
            end
            acgt_pkg::ST_DIGIT: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = acgt_pkg::CH_ZERO | {4'h0, i_rec.digits[r_dig]};
                    if (r_dig == '0) begin
                        n_state = acgt_pkg::ST_HDR_NL;
                    end else begin
                        n_dig = r_dig - acgt_pkg::DIG_W'(1);
                    end
                end
            end
            acgt_pkg::ST_HDR_NL: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_char  = acgt_pkg::CH_NL;
                    n_state = acgt_pkg::ST_REPLAY;
                    n_idx   = '0;
                end
            end
            acgt_pkg::ST_REPLAY: begin
                // i_rd_data already holds entry r_idx: the read address runs one step ahead
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = i_rd_data;
                    if (acgt_pkg::idx_to_run(r_idx) == r_run_len - acgt_pkg::RUN_W'(1)) begin
                        e_last  = 1'b1;
                        n_state = acgt_pkg::ST_IDLE;
                        n_open  = 1'b1;
                    end else begin
                        n_idx = r_idx + acgt_pkg::BUF_AW'(1);
                    end
                end
            end
            acgt_pkg::ST_CLOSE: begin
                if (out_free) begin
                    emit = 1'b1;
                    unique case (r_cnt)
                        acgt_pkg::CL_PLUS: begin
                            e_char = acgt_pkg::CH_PLUS;
                            n_cnt  = acgt_pkg::CL_NL;
                        end
                        acgt_pkg::CL_NL: begin
                            e_char = acgt_pkg::CH_NL;
                            n_cnt  = acgt_pkg::CL_QUAL;
                        end
                        acgt_pkg::CL_QUAL: begin
                            e_char = acgt_pkg::CH_QUAL;
                            e_rep  = r_run_len;
                            n_cnt  = acgt_pkg::CL_END;
                        end
                        acgt_pkg::CL_END: begin
                            e_char    = acgt_pkg::CH_NL;
                            e_last    = 1'b1;
                            n_state   = acgt_pkg::ST_IDLE;
                            n_open    = 1'b0;
                            n_run_len = '0;
                            o_rec.clr = r_eof;
                            o_rec.inc = !r_eof;
                        end
                        default: begin
                            n_cnt = acgt_pkg::CL_PLUS;
                        end
                    endcase
                end
            end
            default: begin
                n_state = acgt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= acgt_pkg::ST_IDLE;
            r_cnt     <= acgt_pkg::CL_PLUS;
            r_dig     <= '0;
            r_idx     <= '0;
            r_run_len <= '0;
            r_open    <= 1'b0;
            r_eof     <= 1'b0;
            r_min_len <= acgt_pkg::MIN_LEN_RESET;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_dig     <= n_dig;
            r_idx     <= n_idx;
            r_run_len <= n_run_len;
            r_open    <= n_open;
            r_eof     <= n_eof;
            if (i_cfg.valid) begin
                r_min_len <= i_cfg.min_length;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ochar <= e_char;
            r_orep  <= e_rep;
            r_olast <= e_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_char   = r_ochar;
    assign o_out.repeat_res = r_orep;
    assign o_out.last       = r_olast;

    `ACGT_CHECK(a_open_has_len, !r_open || (r_run_len != '0), "open record with empty run")
    `ACGT_IMPLY(a_buffered_fits, !r_open, r_run_len <= acgt_pkg::MAX_RUN, "buffered run overflows buffer")
    `ACGT_IMPLY(a_replay_in_run, r_state == acgt_pkg::ST_REPLAY, acgt_pkg::idx_to_run(r_idx) < r_run_len, "replay index past run")

endmodule

### rtl/acgt_run_to_fastq_records.sv
// Base-run to FASTQ record formatter.
// i_in carries one text byte per transaction (in_byte, end_of_file); o_out
// carries FASTQ characters with a repeat count and a last flag that marks the
// final character caused by an input transaction. i_cfg is always ready;
// the user must write min_length only while the block is idle (unenforced).
// The first character of a transaction is registered on o_out the cycle
// after it is accepted. A pass-through base gives one character; a byte
// that opens a record gives '@', the record number and a newline, then the
// buffered bases, one entry per cycle from the base buffer's registered
// read while o_out is ready; a closing byte gives newline, '+', newline,
// 'I', newline. i_in stays low while a multi-character sequence is emitted.
// Reset clears the run length, the record number and the open flag, and sets
// min_length to 10; the base buffer needs no clearing since only entries of
// the current run are read.
// When o_out stalls, the output register holds its transaction and the
// sequencer holds its place; i_in is not ready until the output slot frees.
module acgt_run_to_fastq_records (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acgt_in_if.sink     i_in,
    acgt_out_if.source  o_out,
    acgt_cfg_if.sink    i_cfg
);

    acgt_pkg::t_recno_stat       rec_stat;
    acgt_pkg::t_recno_cmd        rec_cmd;
    acgt_pkg::t_buf_wr           buf_wr;
    logic [acgt_pkg::BUF_AW-1:0] buf_rd_addr;
    logic [7:0]                  buf_rd_data;

    acgt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .i_cfg     (i_cfg),
        .i_rec     (rec_stat),
        .o_rec     (rec_cmd),
        .o_wr      (buf_wr),
        .o_rd_addr (buf_rd_addr),
        .i_rd_data (buf_rd_data)
    );

    acgt_buf u_buf (
        .i_clk     (i_clk),
        .i_wr      (buf_wr),
        .i_rd_addr (buf_rd_addr),
        .o_rd_data (buf_rd_data)
    );

    acgt_recno u_recno (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (rec_cmd),
        .o_stat  (rec_stat)
    );

endmodule
